// File: hw/rtl/rtl_pkg.sv
package rtl_pkg;

    localparam int MAX_ENTRIES_DEF = 64;
    localparam int COORD_BITS_DEF  = 16;
    localparam int KIND_W          = 16;
    localparam int COUNT_W         = 7;
    localparam int INDEX_W         = 6;

    localparam logic FUNC_LOAD  = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;

    localparam logic signed [KIND_W-1:0] KIND_NONE = -16'sd1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CHECK,
        ST_SCAN,
        ST_RESULT
    } t_state;

    typedef struct packed {
        logic cap;
        logic scan_step;
        logic res_keep;
        logic res_hit;
        logic res_miss;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic in_query;
        logic cache_hit;
        logic scan_empty;
        logic rd_hit;
        logic rd_last;
        logic out_free;
    } t_status;

endpackage

// File: hw/rtl/rtl_dpath.sv
module rtl_dpath #(
    parameter int MAX_ENTRIES = rtl_pkg::MAX_ENTRIES_DEF,
    parameter int COORD_BITS  = rtl_pkg::COORD_BITS_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  rtl_pkg::t_cmd                         i_cmd,
    output rtl_pkg::t_status                      o_status,
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [rtl_pkg::COUNT_W-1:0]           i_cfg_entry_count,
    input  logic                                  i_func,
    input  logic [rtl_pkg::INDEX_W-1:0]           i_entry_index,
    input  logic signed [COORD_BITS-1:0]          i_rect_left,
    input  logic signed [COORD_BITS-1:0]          i_rect_top,
    input  logic signed [COORD_BITS-1:0]          i_rect_right,
    input  logic signed [COORD_BITS-1:0]          i_rect_bottom,
    input  logic signed [rtl_pkg::KIND_W-1:0]     i_entry_kind,
    input  logic signed [COORD_BITS-1:0]          i_pos_x,
    input  logic signed [COORD_BITS-1:0]          i_pos_z,
    input  logic                                  i_out_stall,
    output logic                                  o_out_valid,
    output logic signed [rtl_pkg::KIND_W-1:0]     o_current_kind,
    output logic                                  o_transition,
    output logic signed [rtl_pkg::KIND_W-1:0]     o_entered_kind,
    output logic signed [rtl_pkg::KIND_W-1:0]     o_exited_kind
);

    localparam int ADDR_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CNT_W  = $clog2(MAX_ENTRIES + 1);
    localparam int SCAN_W = (CNT_W > rtl_pkg::COUNT_W) ? CNT_W : rtl_pkg::COUNT_W;
    localparam int LDX_W  = (ADDR_W > rtl_pkg::INDEX_W) ? ADDR_W : rtl_pkg::INDEX_W;
    localparam int ENT_W  = 4 * COORD_BITS + rtl_pkg::KIND_W;

    logic [ENT_W-1:0]                   r_mem [MAX_ENTRIES];
    logic [ENT_W-1:0]                   r_rd_data;
    logic [SCAN_W-1:0]                  r_scan_idx;
    logic [SCAN_W-1:0]                  r_rd_pos;
    logic [rtl_pkg::COUNT_W-1:0]        r_entry_count;
    logic signed [COORD_BITS-1:0]       r_pos_x;
    logic signed [COORD_BITS-1:0]       r_pos_z;
    logic signed [COORD_BITS-1:0]       r_c_left;
    logic signed [COORD_BITS-1:0]       r_c_top;
    logic signed [COORD_BITS-1:0]       r_c_right;
    logic signed [COORD_BITS-1:0]       r_c_bottom;
    logic signed [rtl_pkg::KIND_W-1:0]  r_c_kind;
    logic signed [rtl_pkg::KIND_W-1:0]  r_res_kind;
    logic                               r_res_trans;
    logic signed [rtl_pkg::KIND_W-1:0]  r_res_entered;
    logic signed [rtl_pkg::KIND_W-1:0]  r_res_exited;
    logic                               r_out_valid;
    logic signed [rtl_pkg::KIND_W-1:0]  r_out_kind;
    logic                               r_out_trans;
    logic signed [rtl_pkg::KIND_W-1:0]  r_out_entered;
    logic signed [rtl_pkg::KIND_W-1:0]  r_out_exited;

    logic [LDX_W-1:0]                   load_ext;
    logic [ADDR_W-1:0]                  wr_addr;
    logic                               wr_en;
    logic [ENT_W-1:0]                   wr_data;
    logic [SCAN_W-1:0]                  count_ext;
    logic [SCAN_W-1:0]                  scan_limit;
    logic signed [COORD_BITS-1:0]       rd_left;
    logic signed [COORD_BITS-1:0]       rd_top;
    logic signed [COORD_BITS-1:0]       rd_right;
    logic signed [COORD_BITS-1:0]       rd_bottom;
    logic signed [rtl_pkg::KIND_W-1:0]  rd_kind;
    logic                               out_free;

    assign o_cfg_ready = 1'b1;

    assign load_ext = LDX_W'(i_entry_index);
    assign wr_addr  = load_ext[ADDR_W-1:0];
    assign wr_en    = i_cmd.cap && (i_func == rtl_pkg::FUNC_LOAD)
                      && (32'(i_entry_index) < MAX_ENTRIES);
    assign wr_data  = {i_entry_kind, i_rect_left, i_rect_top, i_rect_right, i_rect_bottom};

    assign rd_bottom = r_rd_data[COORD_BITS-1:0];
    assign rd_right  = r_rd_data[2*COORD_BITS-1:COORD_BITS];
    assign rd_top    = r_rd_data[3*COORD_BITS-1:2*COORD_BITS];
    assign rd_left   = r_rd_data[4*COORD_BITS-1:3*COORD_BITS];
    assign rd_kind   = r_rd_data[ENT_W-1:4*COORD_BITS];

    assign count_ext  = SCAN_W'(r_entry_count);
    assign scan_limit = (count_ext > SCAN_W'(MAX_ENTRIES)) ? SCAN_W'(MAX_ENTRIES) : count_ext;

    assign out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        o_status.in_query   = (i_func == rtl_pkg::FUNC_QUERY);
        o_status.cache_hit  = (r_pos_x >= r_c_left) && (r_pos_x <= r_c_right)
                              && (r_pos_z >= r_c_top) && (r_pos_z <= r_c_bottom);
        o_status.scan_empty = (scan_limit == '0);
        o_status.rd_hit     = (r_pos_x >= rd_left) && (r_pos_x <= rd_right)
                              && (r_pos_z >= rd_top) && (r_pos_z <= rd_bottom);
        o_status.rd_last    = (r_rd_pos == scan_limit - 1'b1);
        o_status.out_free   = out_free;
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        r_rd_data <= r_mem[r_scan_idx[ADDR_W-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.cap) begin
            r_pos_x    <= i_pos_x;
            r_pos_z    <= i_pos_z;
            r_scan_idx <= '0;
        end else if (i_cmd.scan_step) begin
            r_scan_idx <= r_scan_idx + 1'b1;
            r_rd_pos   <= r_scan_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry_count <= '0;
        end else if (i_cfg_valid) begin
            r_entry_count <= i_cfg_entry_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_left   <= '0;
            r_c_top    <= '0;
            r_c_right  <= '0;
            r_c_bottom <= '0;
            r_c_kind   <= rtl_pkg::KIND_NONE;
        end else if (i_cmd.res_hit) begin
            r_c_left   <= rd_left;
            r_c_top    <= rd_top;
            r_c_right  <= rd_right;
            r_c_bottom <= rd_bottom;
            r_c_kind   <= rd_kind;
        end else if (i_cmd.res_miss && (r_c_kind != rtl_pkg::KIND_NONE)) begin
            r_c_left   <= '0;
            r_c_top    <= '0;
            r_c_right  <= '0;
            r_c_bottom <= '0;
            r_c_kind   <= rtl_pkg::KIND_NONE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.res_keep) begin
            r_res_kind    <= r_c_kind;
            r_res_trans   <= 1'b0;
            r_res_entered <= '0;
            r_res_exited  <= '0;
        end else if (i_cmd.res_hit) begin
            r_res_kind <= rd_kind;
            if (r_c_kind != rd_kind) begin
                r_res_trans   <= 1'b1;
                r_res_entered <= rd_kind;
                r_res_exited  <= r_c_kind;
            end else begin
                r_res_trans   <= 1'b0;
                r_res_entered <= '0;
                r_res_exited  <= '0;
            end
        end else if (i_cmd.res_miss) begin
            r_res_kind <= rtl_pkg::KIND_NONE;
            if (r_c_kind != rtl_pkg::KIND_NONE) begin
                r_res_trans   <= 1'b1;
                r_res_entered <= rtl_pkg::KIND_NONE;
                r_res_exited  <= r_c_kind;
            end else begin
                r_res_trans   <= 1'b0;
                r_res_entered <= '0;
                r_res_exited  <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_kind    <= r_res_kind;
            r_out_trans   <= r_res_trans;
            r_out_entered <= r_res_entered;
            r_out_exited  <= r_res_exited;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_current_kind = r_out_kind;
    assign o_transition   = r_out_trans;
    assign o_entered_kind = r_out_entered;
    assign o_exited_kind  = r_out_exited;

endmodule

// File: hw/rtl/rtl_ctrl.sv
module rtl_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  rtl_pkg::t_status i_status,
    output rtl_pkg::t_cmd    o_cmd,
    output logic             o_in_stall
);

    rtl_pkg::t_state r_state;
    rtl_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rtl_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_stall = 1'b1;
        case (r_state)
            rtl_pkg::ST_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_cmd.cap = 1'b1;
                    if (i_status.in_query) begin
                        n_state = rtl_pkg::ST_CHECK;
                    end else begin
                        o_cmd.res_keep = 1'b1;
                        n_state        = rtl_pkg::ST_RESULT;
                    end
                end
            end
            rtl_pkg::ST_CHECK: begin
                o_cmd.scan_step = 1'b1;
                if (i_status.cache_hit) begin
                    o_cmd.res_keep = 1'b1;
                    n_state        = rtl_pkg::ST_RESULT;
                end else if (i_status.scan_empty) begin
                    o_cmd.res_miss = 1'b1;
                    n_state        = rtl_pkg::ST_RESULT;
                end else begin
                    n_state = rtl_pkg::ST_SCAN;
                end
            end
            rtl_pkg::ST_SCAN: begin
                if (i_status.rd_hit) begin
                    o_cmd.res_hit = 1'b1;
                    n_state       = rtl_pkg::ST_RESULT;
                end else if (i_status.rd_last) begin
                    o_cmd.res_miss = 1'b1;
                    n_state        = rtl_pkg::ST_RESULT;
                end else begin
                    o_cmd.scan_step = 1'b1;
                end
            end
            rtl_pkg::ST_RESULT: begin
                if (i_status.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = rtl_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = rtl_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// File: hw/rtl/region_trigger_lookup.sv
// Looks up which rectangular region a position falls in. A load request writes one table
// slot, and its result is registered and enters the output register once that is free. A query
// request first tests the cached rectangle. On a miss it scans the table through a single
// registered read port, one slot per cycle, and stops at the first hit or after entry_count
// slots (a larger entry_count still scans only 64 slots). The block takes one request at a
// time and holds its input stalled until the result is in the output register; it then
// accepts the next request. The result can wait in the output register while the next
// request is accepted.
module region_trigger_lookup #(
    parameter int MAX_ENTRIES = rtl_pkg::MAX_ENTRIES_DEF,
    parameter int COORD_BITS  = rtl_pkg::COORD_BITS_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [rtl_pkg::COUNT_W-1:0]           i_cfg_entry_count,
    input  logic                                  i_in_valid,
    output logic                                  o_in_stall,
    input  logic                                  i_func,
    input  logic [rtl_pkg::INDEX_W-1:0]           i_entry_index,
    input  logic signed [COORD_BITS-1:0]          i_rect_left,
    input  logic signed [COORD_BITS-1:0]          i_rect_top,
    input  logic signed [COORD_BITS-1:0]          i_rect_right,
    input  logic signed [COORD_BITS-1:0]          i_rect_bottom,
    input  logic signed [rtl_pkg::KIND_W-1:0]     i_entry_kind,
    input  logic signed [COORD_BITS-1:0]          i_pos_x,
    input  logic signed [COORD_BITS-1:0]          i_pos_z,
    output logic                                  o_out_valid,
    input  logic                                  i_out_stall,
    output logic signed [rtl_pkg::KIND_W-1:0]     o_current_kind,
    output logic                                  o_transition,
    output logic signed [rtl_pkg::KIND_W-1:0]     o_entered_kind,
    output logic signed [rtl_pkg::KIND_W-1:0]     o_exited_kind
);

    rtl_pkg::t_cmd    cmd;
    rtl_pkg::t_status status;

    rtl_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_status   (status),
        .o_cmd      (cmd),
        .o_in_stall (o_in_stall)
    );

    rtl_dpath #(
        .MAX_ENTRIES (MAX_ENTRIES),
        .COORD_BITS  (COORD_BITS)
    ) u_dpath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .o_status          (status),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_entry_count (i_cfg_entry_count),
        .i_func            (i_func),
        .i_entry_index     (i_entry_index),
        .i_rect_left       (i_rect_left),
        .i_rect_top        (i_rect_top),
        .i_rect_right      (i_rect_right),
        .i_rect_bottom     (i_rect_bottom),
        .i_entry_kind      (i_entry_kind),
        .i_pos_x           (i_pos_x),
        .i_pos_z           (i_pos_z),
        .i_out_stall       (i_out_stall),
        .o_out_valid       (o_out_valid),
        .o_current_kind    (o_current_kind),
        .o_transition      (o_transition),
        .o_entered_kind    (o_entered_kind),
        .o_exited_kind     (o_exited_kind)
    );

endmodule
